FILE: src/xcfd_pkg.sv
// ----------------------------------------------------------------------------
// xcfd_pkg - shared types and constants for the XOR checksum frame decoder
// Frame phases, result kind codes and fixed frame constants.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	localparam logic [7:0]  SOF_BYTE    = 8'hFE;
	localparam logic [15:0] LIMIT_RESET = 16'd1024;

	localparam int DATA_W  = 8;
	localparam int WORD_W  = 16;
	localparam int TDATA_W = 56;

	// one-hot frame phase
	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_FUNC_HI = 7'b0000010,
		PH_FUNC_LO = 7'b0000100,
		PH_LEN_HI  = 7'b0001000,
		PH_LEN_LO  = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_CHECK   = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_SUM_GOOD = 2'd1,
		KIND_SUM_BAD  = 2'd2
	} kind_t;

	localparam logic REG_LENGTH_LIMIT = 1'b0;

endpackage

FILE: src/xor_checksum_frame_decoder.sv
// ----------------------------------------------------------------------------
// xor_checksum_frame_decoder - byte stream deframer with XOR checksum
// Hunts for 0xFE, collects function code and length, streams payload beats
// with their index and ends each frame under the length limit with a checksum good/bad beat.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then the decode step
//   writes its result beat into the output register.
// Throughput: one byte per cycle unless a result byte meets a full, stalled output; one phase/XOR update per byte.
// Output stalls back up into the input register, then hold off s_tready.
// Reset (arst_n low, asynchronous): phase to hunting, state and counters
//   cleared, no beats in flight, length_limit back to 1024.
module xor_checksum_frame_decoder
	import xcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input byte stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,    // [7:0] rx_byte
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] data_byte, [23:8] byte_index, [39:24] function_code,
	// [55:40] payload_length
	output logic [TDATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,    // [1:0] kind
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// configuration register
	logic [WORD_W-1:0] length_limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LENGTH_LIMIT) begin
			length_limit_q <= pwdata[WORD_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_LENGTH_LIMIT) begin
			prdata = {16'd0, length_limit_q};
		end
	end

	// input register
	logic              in_v_s1;
	logic [DATA_W-1:0] in_byte_s1;

	// frame state
	phase_t            phase_q;
	logic [WORD_W-1:0] function_q;
	logic [WORD_W-1:0] length_q;
	logic [WORD_W-1:0] count_q;
	logic [DATA_W-1:0] xor_q;

	// output register
	logic              out_v_q;
	kind_t             out_kind_q;
	logic [DATA_W-1:0] out_data_q;
	logic [WORD_W-1:0] out_index_q;
	logic [WORD_W-1:0] out_func_q;
	logic [WORD_W-1:0] out_len_q;

	// decode step
	phase_t            phase_d;
	logic [WORD_W-1:0] function_d;
	logic [WORD_W-1:0] length_d;
	logic [WORD_W-1:0] count_d;
	logic [DATA_W-1:0] xor_d;
	logic [WORD_W-1:0] count_inc;
	logic [WORD_W-1:0] len_full;
	logic              res_v;
	kind_t             res_kind;
	logic [WORD_W-1:0] res_index;
	logic              adv;

	assign count_inc = count_q + 16'd1;
	assign len_full  = {length_q[15:8], in_byte_s1};

	always_comb begin
		phase_d    = phase_q;
		function_d = function_q;
		length_d   = length_q;
		count_d    = count_q;
		xor_d      = xor_q ^ in_byte_s1;
		res_v      = 1'b0;
		res_kind   = KIND_PAYLOAD;
		res_index  = count_q;
		case (phase_q)
			PH_FUNC_HI: begin
				function_d = {in_byte_s1, 8'd0};
				phase_d    = PH_FUNC_LO;
			end
			PH_FUNC_LO: begin
				function_d = {function_q[15:8], in_byte_s1};
				phase_d    = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = {in_byte_s1, 8'd0};
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = len_full;
				count_d  = '0;
				if (len_full == '0) begin
					phase_d = PH_CHECK;
				end else if (len_full < length_limit_q) begin
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				res_v   = 1'b1;
				count_d = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res_v     = 1'b1;
				res_kind  = (xor_q == in_byte_s1) ? KIND_SUM_GOOD : KIND_SUM_BAD;
				res_index = '0;
				xor_d     = xor_q;
				phase_d   = PH_HUNT;
			end
			default: begin
				// hunting: anything but the start byte is dropped
				xor_d = xor_q;
				if (in_byte_s1 == SOF_BYTE) begin
					xor_d   = SOF_BYTE;
					count_d = '0;
					phase_d = PH_FUNC_HI;
				end
			end
		endcase
	end

	// a byte with no result moves on even when the output is full
	assign adv      = in_v_s1 && (!res_v || !out_v_q || m_tready);
	assign s_tready = !in_v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_tready) begin
			in_v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			function_q <= '0;
			length_q   <= '0;
			count_q    <= '0;
			xor_q      <= '0;
		end else if (adv) begin
			phase_q    <= phase_d;
			function_q <= function_d;
			length_q   <= length_d;
			count_q    <= count_d;
			xor_q      <= xor_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && res_v) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			out_kind_q  <= res_kind;
			out_data_q  <= in_byte_s1;
			out_index_q <= res_index;
			out_func_q  <= function_q;
			out_len_q   <= length_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_len_q, out_func_q, out_index_q, out_data_q};
	assign m_tuser  = out_kind_q;

	// payload beats always fall inside the decoded length
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[23:8] < m_tdata[55:40])
		else $error("payload beat index beyond frame length");

	// end beats carry a zero index
	a_end_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata[23:8] == '0)
		else $error("end beat with nonzero index");

	// in the payload phase the count stays below a nonzero length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> length_q != '0 && count_q < length_q)
		else $error("payload count out of range");

	// a blocked byte waits in the input register unchanged
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_v_s1 && !adv |=> in_v_s1 && $stable(in_byte_s1))
		else $error("input register lost a blocked byte");

	// a new result is only written when the output slot is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result overwritten");

endmodule
